>>> design/bsa_pkg.sv
// Shared types, command codes and defaults for the bitmap sector allocator.
`timescale 1ns / 1ps
package bsa_pkg;

	localparam int MAP_BITS_DEF    = 65536;
	localparam int REGION_BITS_DEF = 4096;
	localparam int WORD_BITS_DEF   = 64;

	localparam int CMD_W    = 3;
	localparam int SECTOR_W = 16;
	localparam int VOL_W    = 17;

	localparam logic [VOL_W-1:0] VOL_RESET = 17'h10000;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
	localparam logic [CMD_W-1:0] CMD_USED  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TEST  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [SECTOR_W-1:0] sector;
	} bsa_req_t;

	typedef struct packed {
		logic                status;
		logic [SECTOR_W-1:0] granted_sector;
		logic                is_used;
		logic [VOL_W-1:0]    free_count;
	} bsa_rsp_t;

endpackage

>>> design/bitmap_sector_allocator_unit.sv
// Bitmap sector allocator top level: sequencer, scan datapath and use-map RAM.
//
// channel   direction  handshake                 payload
// command   in         start & !busy             req   (bsa_req_t)
// result    out        done, one cycle           rsp   (bsa_rsp_t)
// config    in         cfg_we                    cfg_wdata (volume_sectors)
//
// One map word passes through the RAM read port per cycle.
// Mark used / mark free / test: one read-modify-write. Count free: scans the covering words.
// Allocate: scans the covering words from the hint region and stops at the first free bit.
// Unknown command: busy stays low.
// Clear all: zeroes every map word. After reset a clearing pass over MAP_WORDS
// words (1024 at defaults) runs with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module bitmap_sector_allocator_unit import bsa_pkg::*; #(
	parameter int MAP_BITS    = MAP_BITS_DEF,
	parameter int REGION_BITS = REGION_BITS_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bsa_req_t         req,
	output logic             busy,
	output logic             done,
	output bsa_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [VOL_W-1:0] cfg_wdata
);

	localparam int MAP_WORDS    = MAP_BITS / WORD_BITS;
	localparam int REGION_WORDS = REGION_BITS / WORD_BITS;
	localparam int REGION_COUNT = MAP_BITS / REGION_BITS;
	localparam int AW    = $clog2(MAP_WORDS);
	localparam int WB_W  = $clog2(WORD_BITS);
	localparam int SEC_W = AW + WB_W;
	localparam int RWL   = $clog2(REGION_WORDS);
	localparam int RBL   = $clog2(REGION_BITS);
	localparam int RG_W  = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam int CNT_W = $clog2(REGION_COUNT + 1);
	localparam int LW    = $clog2(MAP_WORDS + 1);
	localparam int CW    = $clog2(MAP_BITS + 1);
	localparam int NB    = WORD_BITS / 8;
	localparam int NBW   = (NB > 1) ? $clog2(NB) : 1;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ALLOC = 3'd2;
	localparam logic [2:0] ST_CNT   = 3'd3;
	localparam logic [2:0] ST_RMW   = 3'd4;

	logic [2:0]          state_q;
	logic [VOL_W-1:0]    vol_q;
	logic [RG_W-1:0]     hint_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [SECTOR_W-1:0] sec_q;
	logic [AW-1:0]       clr_addr_q;
	logic                clr_res_q;
	logic [AW-1:0]       scan_addr_q;
	logic [LW-1:0]       rd_left_q;
	logic [CW-1:0]       acc_q;
	logic                done_q;
	bsa_rsp_t            rsp_q;
	bsa_rsp_t            rsp_d;
	logic                fin;

	logic                v_s1;
	logic [AW-1:0]       addr_s1;
	logic                v_s2;
	logic [3:0]          bcnt_s2 [NB];

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [31:0]          maps_raw;
	logic [CNT_W-1:0]     maps;
	logic [RG_W-1:0]      start_rg;
	logic [31:0]          scan_rg;
	logic                 scan_wrap;
	logic                 scanning;
	logic                 issue;
	logic                 accept;

	logic [WORD_BITS-1:0] masked;
	logic                 hit;
	logic [NBW-1:0]       kb;
	logic [7:0]           byte_sel;
	logic [2:0]           bp;
	logic [WB_W-1:0]      bit_idx;
	logic [SEC_W-1:0]     grant_sec;
	logic                 alloc_full;
	logic                 alloc_stop;

	logic [3:0]           bc [NB];
	logic [WB_W:0]        bsum;

	logic [SEC_W-1:0]     req_ext;
	logic [SEC_W-1:0]     sec_ext;
	logic [AW-1:0]        rmw_idx;
	logic [WB_W-1:0]      rmw_bit;
	logic [WORD_BITS-1:0] rmw_onehot;
	logic                 in_map;

	bsa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// covering regions, capped at the map
	assign maps_raw = (32'(vol_q) + 32'(REGION_BITS - 1)) >> RBL;
	assign maps     = (maps_raw > 32'(REGION_COUNT)) ? CNT_W'(REGION_COUNT) : CNT_W'(maps_raw);
	assign start_rg = (32'(hint_q) < 32'(maps)) ? hint_q : '0;

	assign scan_rg   = 32'(scan_addr_q) >> RWL;
	assign scan_wrap = (((32'(scan_addr_q) + 32'd1) & 32'(REGION_WORDS - 1)) == 32'd0)
		&& ((scan_rg + 32'd1) == 32'(maps));
	assign scanning   = (state_q == ST_ALLOC) || (state_q == ST_CNT);
	assign alloc_stop = (state_q == ST_ALLOC) && v_s1 && hit;
	assign issue      = scanning && (rd_left_q != '0) && !alloc_stop;

	// lowest clear bit, sector 0 excluded
	assign masked = ram_rdata | ((addr_s1 == '0) ? WORD_BITS'(1) : '0);
	assign hit    = ~&masked;

	always_comb begin
		kb = '0;
		for (int k = NB - 1; k >= 0; k--) begin
			if (~&masked[8*k +: 8]) begin
				kb = NBW'(k);
			end
		end
	end

	assign byte_sel = masked[8*kb +: 8];

	always_comb begin
		bp = '0;
		for (int j = 7; j >= 0; j--) begin
			if (!byte_sel[j]) begin
				bp = 3'(j);
			end
		end
	end

	assign bit_idx    = WB_W'(32'(kb) * 8 + 32'(bp));
	assign grant_sec  = {addr_s1, bit_idx};
	assign alloc_full = 32'(grant_sec) >= 32'(vol_q);

	// per-byte popcount, then sum of bytes
	always_comb begin
		for (int k = 0; k < NB; k++) begin
			bc[k] = '0;
			for (int j = 0; j < 8; j++) begin
				bc[k] = bc[k] + 4'(ram_rdata[8*k + j]);
			end
		end
	end

	always_comb begin
		bsum = '0;
		for (int k = 0; k < NB; k++) begin
			bsum = bsum + (WB_W + 1)'(bcnt_s2[k]);
		end
	end

	assign req_ext    = SEC_W'(req.sector);
	assign sec_ext    = SEC_W'(sec_q);
	assign rmw_idx    = sec_ext[SEC_W-1:WB_W];
	assign rmw_bit    = sec_ext[WB_W-1:0];
	assign rmw_onehot = WORD_BITS'(1) << rmw_bit;
	assign in_map     = 32'(sec_q) < 32'(MAP_BITS);

	assign ram_raddr = scanning ? scan_addr_q : req_ext[SEC_W-1:WB_W];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_ALLOC: begin
				if (v_s1 && hit && !alloc_full) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_idx);
				end
			end
			ST_RMW: begin
				if (in_map && (cmd_q == CMD_USED || cmd_q == CMD_FREE)) begin
					ram_we    = 1'b1;
					ram_waddr = rmw_idx;
					ram_wdata = (cmd_q == CMD_USED) ? (ram_rdata | rmw_onehot)
						: (ram_rdata & ~rmw_onehot);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		fin   = 1'b0;
		rsp_d = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.cmd != CMD_ALLOC && req.cmd != CMD_USED
					&& req.cmd != CMD_FREE && req.cmd != CMD_TEST
					&& req.cmd != CMD_COUNT && req.cmd != CMD_CLEAR) begin
					fin = 1'b1;
				end
			end
			ST_CLR: begin
				fin = clr_res_q && (clr_addr_q == AW'(MAP_WORDS - 1));
			end
			ST_ALLOC: begin
				if (v_s1 && hit) begin
					fin                  = 1'b1;
					rsp_d.status         = alloc_full;
					rsp_d.granted_sector = alloc_full ? '0 : SECTOR_W'(grant_sec);
				end else if (rd_left_q == '0 && !v_s1) begin
					fin          = 1'b1;
					rsp_d.status = 1'b1;
				end
			end
			ST_CNT: begin
				if (rd_left_q == '0 && !v_s1 && !v_s2) begin
					fin              = 1'b1;
					rsp_d.free_count = (32'(vol_q) > 32'(acc_q))
						? VOL_W'(32'(vol_q) - 32'(acc_q)) : '0;
				end
			end
			ST_RMW: begin
				fin           = 1'b1;
				rsp_d.is_used = (cmd_q == CMD_TEST) ? (in_map ? ram_rdata[rmw_bit] : 1'b1)
					: 1'b0;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			vol_q       <= VOL_RESET;
			hint_q      <= '0;
			clr_addr_q  <= '0;
			clr_res_q   <= 1'b0;
			scan_addr_q <= '0;
			rd_left_q   <= '0;
			acc_q       <= '0;
			done_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			done_q <= fin;
			v_s1   <= issue;
			v_s2   <= v_s1 && (state_q == ST_CNT);
			if (cfg_we) begin
				vol_q <= cfg_wdata;
			end
			if (v_s2) begin
				acc_q <= acc_q + CW'(bsum);
			end
			if (issue) begin
				scan_addr_q <= scan_wrap ? '0 : scan_addr_q + 1'b1;
				rd_left_q   <= rd_left_q - 1'b1;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
						state_q   <= ST_IDLE;
						clr_res_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (req.cmd)
							CMD_ALLOC: begin
								state_q     <= ST_ALLOC;
								scan_addr_q <= AW'(32'(start_rg) * REGION_WORDS);
								rd_left_q   <= LW'(32'(maps) * REGION_WORDS);
							end
							CMD_COUNT: begin
								state_q     <= ST_CNT;
								scan_addr_q <= '0;
								rd_left_q   <= LW'(32'(maps) * REGION_WORDS);
								acc_q       <= '0;
							end
							CMD_USED, CMD_FREE, CMD_TEST: begin
								state_q <= ST_RMW;
							end
							CMD_CLEAR: begin
								state_q    <= ST_CLR;
								clr_addr_q <= '0;
								clr_res_q  <= 1'b1;
								hint_q     <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					if (fin) begin
						state_q <= ST_IDLE;
						if (hit && !alloc_full) begin
							hint_q <= RG_W'(32'(addr_s1) >> RWL);
						end
					end
				end
				ST_CNT: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RMW: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rsp_q   <= rsp_d;
		addr_s1 <= scan_addr_q;
		if (accept) begin
			cmd_q <= req.cmd;
			sec_q <= req.sector;
		end
		for (int k = 0; k < NB; k++) begin
			bcnt_s2[k] <= bc[k];
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_full_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |-> (rsp.granted_sector == '0 && rsp.free_count == '0))
		else $error("full status with nonzero payload");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_left_q <= LW'(MAP_WORDS))
		else $error("scan length beyond map");

	a_clr_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> (ram_we && ram_wdata == '0))
		else $error("clearing pass without zero write");

	a_cnt_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_CNT))
		else $error("count stage valid outside count");

endmodule

>>> design/bsa_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module bsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
